/* design/wwge_pkg.sv */
// shared types, codes and constants of the wireworld grid engine
// used by the top, controller and datapath of the block; no dependencies

package wwge_pkg;

    localparam int MAX_COLS_DEF = 64;
    localparam int MAX_ROWS_DEF = 64;

    // grid size registers
    localparam int DIM_W = 7;
    localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(64);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_WRAP   = 2'd2;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_STEP  = 2'd2;

    localparam logic [1:0] ST_EMPTY = 2'd0;
    localparam logic [1:0] ST_HEAD  = 2'd1;
    localparam logic [1:0] ST_TAIL  = 2'd2;
    localparam logic [1:0] ST_COND  = 2'd3;

    localparam logic [15:0] LVL_FULL = 16'hFFFF;
    localparam logic [15:0] LVL_TAIL = 16'((32'(LVL_FULL) * 3) / 4);
    localparam logic [15:0] LVL_COND = 16'(32'(LVL_FULL) / 4);

    typedef struct packed {
        logic [1:0] op;
        logic [5:0] col;
        logic [5:0] row;
        logic [1:0] new_state;
    } req_t;

    typedef struct packed {
        logic [1:0]  cell_state;
        logic [15:0] level;
        logic        in_range;
        logic        live_electrons;
    } rsp_t;

    // controller to datapath
    typedef struct packed {
        logic load_item;
        logic do_write;
        logic do_read;
        logic rd_capture;
        logic gen_start;
        logic gen_issue;
        logic copy_issue;
        logic live_commit;
        logic clr_issue;
        logic out_load;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [1:0] op;
        logic       grid_empty;
        logic       gen_last;
        logic       copy_last;
        logic       clr_last;
        logic       out_free;
    } sts_t;

    function automatic logic [15:0] level_of(input logic [1:0] s);
        logic [15:0] lv;
        case (s)
            ST_HEAD: lv = LVL_FULL;
            ST_TAIL: lv = LVL_TAIL;
            ST_COND: lv = LVL_COND;
            default: lv = 16'd0;
        endcase
        return lv;
    endfunction

endpackage

/* design/wireworld_grid_engine_unit.sv */
// top level of the wireworld grid engine: controller plus datapath
// depends on wwge_pkg, wwge_ctrl, wwge_dpath (which holds the wwge_ram instances)
//
//   channel  direction  handshake              beat
//   req      in         req_valid / req_stall  wwge_pkg::req_t (op, col, row, new_state)
//   rsp      out        rsp_valid / rsp_stall  wwge_pkg::rsp_t (one beat per req beat)
//   cfg      in         cfg_valid / cfg_ready  cfg_index, cfg_data (ready always high)
//
// a write or op 3 passes S_EXEC and S_FIN, a read S_EXEC, S_RDWAIT and S_FIN, before the
// result is loaded into rsp; req stays stalled until the controller is back in S_IDLE
// a step on a W x H grid scans W+2 columns for each of its H rows (an empty grid goes
// straight to the commit): the scan issues three cell reads per column through the single
// read port of the cell store, then copies back
// after reset a clearing pass over all MAX_COLS*MAX_ROWS cells (4096 by default) stalls req
// one item is worked at a time; the next req beat is taken while a result waits on rsp

module wireworld_grid_engine_unit #(
    parameter int MAX_COLS = wwge_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = wwge_pkg::MAX_ROWS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_stall,
    input  wwge_pkg::req_t                  req,
    output logic                            rsp_valid,
    input  logic                            rsp_stall,
    output wwge_pkg::rsp_t                  rsp,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [wwge_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [wwge_pkg::CFG_DATA_W-1:0] cfg_data
);

    wwge_pkg::cmd_t cmd;
    wwge_pkg::sts_t sts;

    assign cfg_ready = 1'b1;

    wwge_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    wwge_dpath #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .req       (req),
        .cfg_valid (cfg_valid & cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

/* design/wwge_ram.sv */
// generic single-write, single-read ram with registered read data
// no dependencies

module wwge_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 4096
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic                                        re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* design/wwge_ctrl.sv */
// sequencing state machine of the wireworld grid engine
// depends on wwge_pkg for the command and status structs and op codes

module wwge_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    output wwge_pkg::cmd_t cmd,
    input  wwge_pkg::sts_t sts
);

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_EXEC   = 4'd2;
    localparam logic [3:0] S_RDWAIT = 4'd3;
    localparam logic [3:0] S_GEN    = 4'd4;
    localparam logic [3:0] S_GDRAIN = 4'd5;
    localparam logic [3:0] S_COPY   = 4'd6;
    localparam logic [3:0] S_COMMIT = 4'd7;
    localparam logic [3:0] S_FIN    = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        req_stall  = (state_reg != S_IDLE);
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_issue = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (sts.op)
                    wwge_pkg::OP_WRITE:
                    begin
                        cmd.do_write = 1'b1;
                        state_next   = S_FIN;
                    end
                    wwge_pkg::OP_READ:
                    begin
                        cmd.do_read = 1'b1;
                        state_next  = S_RDWAIT;
                    end
                    wwge_pkg::OP_STEP:
                    begin
                        cmd.gen_start = 1'b1;
                        // empty grid: nothing to scan, live flag just clears
                        state_next    = sts.grid_empty ? S_COMMIT : S_GEN;
                    end
                    default:
                    begin
                        state_next = S_FIN;
                    end
                endcase
            end
            S_RDWAIT:
            begin
                cmd.rd_capture = 1'b1;
                state_next     = S_FIN;
            end
            S_GEN:
            begin
                cmd.gen_issue = 1'b1;
                if (sts.gen_last)
                begin
                    state_next = S_GDRAIN;
                end
            end
            S_GDRAIN:
            begin
                state_next = S_COPY;
            end
            S_COPY:
            begin
                cmd.copy_issue = 1'b1;
                if (sts.copy_last)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                cmd.live_commit = 1'b1;
                state_next      = S_FIN;
            end
            S_FIN:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* design/wwge_dpath.sv */
// datapath: config registers, cell and next-generation rams, scan counters,
// 3x3 neighbour window and result register; depends on wwge_pkg and wwge_ram

module wwge_dpath #(
    parameter int MAX_COLS = wwge_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = wwge_pkg::MAX_ROWS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  wwge_pkg::cmd_t                      cmd,
    output wwge_pkg::sts_t                      sts,
    input  wwge_pkg::req_t                      req,
    input  logic                                cfg_valid,
    input  logic [wwge_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [wwge_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output wwge_pkg::rsp_t                      rsp
);

    localparam int CELLS = MAX_COLS * MAX_ROWS;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int EW    = wwge_pkg::DIM_W;
    localparam int LW    = EW + 1;

    localparam logic [1:0] SLOT_TOP = 2'd0;
    localparam logic [1:0] SLOT_MID = 2'd1;
    localparam logic [1:0] SLOT_BOT = 2'd2;

    function automatic logic [AW-1:0] cell_addr(input logic [EW-1:0] r,
                                                 input logic [EW-1:0] c);
        return AW'(r) * AW'(MAX_COLS) + AW'(c);
    endfunction

    // configuration
    logic [EW-1:0] gw_reg;
    logic [EW-1:0] gh_reg;
    logic          wrap_reg;
    logic [EW-1:0] w_eff;
    logic [EW-1:0] h_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gw_reg   <= wwge_pkg::DIM_RESET;
            gh_reg   <= wwge_pkg::DIM_RESET;
            wrap_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                wwge_pkg::REG_GRID_WIDTH:  gw_reg   <= EW'(cfg_data);
                wwge_pkg::REG_GRID_HEIGHT: gh_reg   <= EW'(cfg_data);
                wwge_pkg::REG_EDGE_WRAP:   wrap_reg <= cfg_data[0];
                default:                   ;
            endcase
        end
    end

    assign w_eff = (32'(gw_reg) > MAX_COLS) ? EW'(MAX_COLS) : gw_reg;
    assign h_eff = (32'(gh_reg) > MAX_ROWS) ? EW'(MAX_ROWS) : gh_reg;

    // latched item
    wwge_pkg::req_t item_reg;
    logic           inr;
    logic [AW-1:0]  item_addr;

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg <= req;
        end
    end

    assign inr       = (EW'(item_reg.col) < w_eff) && (EW'(item_reg.row) < h_eff);
    assign item_addr = cell_addr(EW'(item_reg.row), EW'(item_reg.col));

    // ram ports
    logic          cs_we;
    logic [AW-1:0] cs_waddr;
    logic [1:0]    cs_wdata;
    logic          cs_re;
    logic [AW-1:0] cs_raddr;
    logic [1:0]    cs_q;
    logic          ns_we;
    logic [1:0]    ns_wdata;
    logic [1:0]    ns_q;

    // clearing pass after reset
    logic [AW-1:0] clr_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
        end
        else if (cmd.clr_issue)
        begin
            clr_addr_reg <= clr_addr_reg + AW'(1);
        end
    end

    // generation scan: three reads per loaded column, rows above, at and below
    logic [EW-1:0] gy_reg;
    logic [LW-1:0] lcnt_reg;
    logic [1:0]    slot_reg;
    logic [LW-1:0] wp1;
    logic [EW-1:0] g_row;
    logic [EW-1:0] g_col;
    logic          g_row_void;
    logic          g_col_void;
    logic [AW-1:0] g_addr;
    logic [AW-1:0] g_center;
    logic          g_is_cell;

    assign wp1 = LW'(w_eff) + LW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gy_reg   <= '0;
            lcnt_reg <= '0;
            slot_reg <= SLOT_TOP;
        end
        else if (cmd.gen_start)
        begin
            gy_reg   <= '0;
            lcnt_reg <= '0;
            slot_reg <= SLOT_TOP;
        end
        else if (cmd.gen_issue)
        begin
            if (slot_reg == SLOT_BOT)
            begin
                slot_reg <= SLOT_TOP;
                if (lcnt_reg == wp1)
                begin
                    lcnt_reg <= '0;
                    gy_reg   <= gy_reg + EW'(1);
                end
                else
                begin
                    lcnt_reg <= lcnt_reg + LW'(1);
                end
            end
            else
            begin
                slot_reg <= slot_reg + 2'd1;
            end
        end
    end

    always_comb
    begin
        g_col_void = 1'b0;
        g_row_void = 1'b0;
        if (lcnt_reg == '0)
        begin
            g_col      = w_eff - EW'(1);
            g_col_void = !wrap_reg;
        end
        else if (lcnt_reg == wp1)
        begin
            g_col      = '0;
            g_col_void = !wrap_reg;
        end
        else
        begin
            g_col = EW'(lcnt_reg - LW'(1));
        end
        case (slot_reg)
            SLOT_TOP:
            begin
                if (gy_reg == '0)
                begin
                    g_row      = h_eff - EW'(1);
                    g_row_void = !wrap_reg;
                end
                else
                begin
                    g_row = gy_reg - EW'(1);
                end
            end
            SLOT_BOT:
            begin
                if (gy_reg == h_eff - EW'(1))
                begin
                    g_row      = '0;
                    g_row_void = !wrap_reg;
                end
                else
                begin
                    g_row = gy_reg + EW'(1);
                end
            end
            default:
            begin
                g_row = gy_reg;
            end
        endcase
    end

    assign g_addr    = cell_addr(g_row, g_col);
    assign g_is_cell = (lcnt_reg >= LW'(2));
    assign g_center  = cell_addr(gy_reg, EW'(lcnt_reg - LW'(2)));

    // read tag, registered with each scan read so that it meets the read data
    logic          tg_valid_reg;
    logic [1:0]    tg_slot_reg;
    logic          tg_void_reg;
    logic          tg_cell_reg;
    logic [AW-1:0] tg_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tg_valid_reg <= 1'b0;
        end
        else
        begin
            tg_valid_reg <= cmd.gen_issue;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.gen_issue)
        begin
            tg_slot_reg <= slot_reg;
            tg_void_reg <= g_row_void | g_col_void;
            tg_cell_reg <= g_is_cell;
            tg_addr_reg <= g_center;
        end
    end

    // neighbour window: left column heads, middle column, and the column coming in
    logic       top_head_reg;
    logic [1:0] mid_state_reg;
    logic [2:0] win_l_reg;
    logic       win_m_top_reg;
    logic [1:0] win_m_state_reg;
    logic       win_m_bot_reg;
    logic [1:0] rd_state;
    logic       rd_head;
    logic [7:0] nb;
    logic [3:0] nb_cnt;
    logic [1:0] cell_next;
    logic       col_done;
    logic       live_set;

    assign rd_state = tg_void_reg ? wwge_pkg::ST_EMPTY : cs_q;
    assign rd_head  = (rd_state == wwge_pkg::ST_HEAD);
    assign col_done = tg_valid_reg && (tg_slot_reg == SLOT_BOT);

    always_comb
    begin
        nb = {win_l_reg, win_m_top_reg, win_m_bot_reg, top_head_reg,
              (mid_state_reg == wwge_pkg::ST_HEAD), rd_head};
        nb_cnt = '0;
        for (int i = 0; i < 8; i++)
        begin
            nb_cnt = nb_cnt + 4'(nb[i]);
        end
        case (win_m_state_reg)
            wwge_pkg::ST_HEAD: cell_next = wwge_pkg::ST_TAIL;
            wwge_pkg::ST_TAIL: cell_next = wwge_pkg::ST_COND;
            wwge_pkg::ST_COND:
                cell_next = (nb_cnt == 4'd1 || nb_cnt == 4'd2) ? wwge_pkg::ST_HEAD
                                                               : wwge_pkg::ST_COND;
            default:           cell_next = wwge_pkg::ST_EMPTY;
        endcase
    end

    assign ns_we    = col_done && tg_cell_reg;
    assign ns_wdata = cell_next;
    assign live_set = ns_we && (cell_next == wwge_pkg::ST_HEAD ||
                                cell_next == wwge_pkg::ST_TAIL);

    always_ff @(posedge clk)
    begin
        if (tg_valid_reg)
        begin
            case (tg_slot_reg)
                SLOT_TOP: top_head_reg  <= rd_head;
                SLOT_MID: mid_state_reg <= rd_state;
                SLOT_BOT:
                begin
                    win_l_reg       <= {win_m_top_reg,
                                        (win_m_state_reg == wwge_pkg::ST_HEAD),
                                        win_m_bot_reg};
                    win_m_top_reg   <= top_head_reg;
                    win_m_state_reg <= mid_state_reg;
                    win_m_bot_reg   <= rd_head;
                end
                default: ;
            endcase
        end
    end

    // live flags
    logic live_acc_reg;
    logic live_flag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_acc_reg  <= 1'b0;
            live_flag_reg <= 1'b0;
        end
        else
        begin
            if (cmd.gen_start)
            begin
                live_acc_reg <= 1'b0;
            end
            else if (live_set)
            begin
                live_acc_reg <= 1'b1;
            end
            if (cmd.live_commit)
            begin
                live_flag_reg <= live_acc_reg;
            end
        end
    end

    // copy pass: next store back into the cell store over the active grid
    logic [EW-1:0] cp_x_reg;
    logic [EW-1:0] cp_y_reg;
    logic          cp_valid_reg;
    logic [AW-1:0] cp_addr_reg;
    logic [AW-1:0] cp_addr;
    logic          cp_row_end;

    assign cp_addr    = cell_addr(cp_y_reg, cp_x_reg);
    assign cp_row_end = (cp_x_reg == w_eff - EW'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cp_x_reg     <= '0;
            cp_y_reg     <= '0;
            cp_valid_reg <= 1'b0;
        end
        else
        begin
            cp_valid_reg <= cmd.copy_issue;
            if (cmd.gen_start)
            begin
                cp_x_reg <= '0;
                cp_y_reg <= '0;
            end
            else if (cmd.copy_issue)
            begin
                if (cp_row_end)
                begin
                    cp_x_reg <= '0;
                    cp_y_reg <= cp_y_reg + EW'(1);
                end
                else
                begin
                    cp_x_reg <= cp_x_reg + EW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.copy_issue)
        begin
            cp_addr_reg <= cp_addr;
        end
    end

    // cell store port muxing
    always_comb
    begin
        cs_we    = 1'b0;
        cs_waddr = cp_addr_reg;
        cs_wdata = ns_q;
        if (cmd.clr_issue)
        begin
            cs_we    = 1'b1;
            cs_waddr = clr_addr_reg;
            cs_wdata = wwge_pkg::ST_EMPTY;
        end
        else if (cmd.do_write)
        begin
            cs_we    = inr;
            cs_waddr = item_addr;
            cs_wdata = item_reg.new_state;
        end
        else if (cp_valid_reg)
        begin
            cs_we = 1'b1;
        end
    end

    assign cs_re    = cmd.do_read | cmd.gen_issue;
    assign cs_raddr = cmd.gen_issue ? g_addr : item_addr;

    wwge_ram #(
        .WIDTH (2),
        .DEPTH (CELLS)
    ) u_cell_store (
        .clk   (clk),
        .we    (cs_we),
        .waddr (cs_waddr),
        .wdata (cs_wdata),
        .re    (cs_re),
        .raddr (cs_raddr),
        .rdata (cs_q)
    );

    wwge_ram #(
        .WIDTH (2),
        .DEPTH (CELLS)
    ) u_next_store (
        .clk   (clk),
        .we    (ns_we),
        .waddr (tg_addr_reg),
        .wdata (ns_wdata),
        .re    (cmd.copy_issue),
        .raddr (cp_addr),
        .rdata (ns_q)
    );

    // read result and output register
    logic [1:0]     rd_cell_reg;
    wwge_pkg::rsp_t res;
    wwge_pkg::rsp_t out_reg;
    logic           out_valid_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.rd_capture)
        begin
            rd_cell_reg <= cs_q;
        end
    end

    always_comb
    begin
        res.cell_state     = (item_reg.op == wwge_pkg::OP_READ && inr) ? rd_cell_reg
                                                                        : wwge_pkg::ST_EMPTY;
        res.level          = wwge_pkg::level_of(res.cell_state);
        res.in_range       = (item_reg.op == wwge_pkg::OP_WRITE ||
                              item_reg.op == wwge_pkg::OP_READ) ? inr : 1'b0;
        res.live_electrons = live_flag_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_reg <= res;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    // status
    assign sts.op         = item_reg.op;
    assign sts.grid_empty = (w_eff == '0) || (h_eff == '0);
    assign sts.gen_last   = (slot_reg == SLOT_BOT) && (lcnt_reg == wp1) &&
                            (gy_reg == h_eff - EW'(1));
    assign sts.copy_last  = cp_row_end && (cp_y_reg == h_eff - EW'(1));
    assign sts.clr_last   = (clr_addr_reg == AW'(CELLS - 1));
    assign sts.out_free   = !out_valid_reg || !rsp_stall;

endmodule

/* tb/wireworld_grid_engine_checker.sv */
// reply checker for the wireworld grid engine: watches req, rsp and cfg beats,
// keeps its own copy of the grid and registers, and compares every rsp beat in order
// depends on wwge_pkg for the beat types, register indexes and cell codes

module wireworld_grid_engine_checker
    import wwge_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    input  logic                  req_stall,
    input  req_t                  req,
    input  logic                  rsp_valid,
    input  logic                  rsp_stall,
    input  rsp_t                  rsp,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int unsigned           fail_cnt,
    output int unsigned           replies_due
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COLS  = MAX_COLS_DEF;
    localparam int ROWS  = MAX_ROWS_DEF;
    localparam int CELLS = COLS * ROWS;

    localparam logic [15:0] LEVEL_HEAD = 16'hFFFF;
    localparam logic [15:0] LEVEL_TAIL = 16'hBFFF;
    localparam logic [15:0] LEVEL_COND = 16'h3FFF;

    logic [1:0]       cells    [CELLS];
    logic [1:0]       next_gen [CELLS];
    logic [DIM_W-1:0] grid_w;
    logic [DIM_W-1:0] grid_h;
    logic             wrap_on;
    logic             live;
    rsp_t             pending_replies[$];
    rsp_t             want;

    // sizes above the array bounds saturate
    function automatic int active_cols();
        return (int'(grid_w) > COLS) ? COLS : int'(grid_w);
    endfunction

    function automatic int active_rows();
        return (int'(grid_h) > ROWS) ? ROWS : int'(grid_h);
    endfunction

    function automatic logic [15:0] level_for(logic [1:0] s);
        case (s)
            ST_HEAD: return LEVEL_HEAD;
            ST_TAIL: return LEVEL_TAIL;
            ST_COND: return LEVEL_COND;
            default: return 16'd0;
        endcase
    endfunction

    function automatic int head_at(int x, int y, int w, int h);
        if (wrap_on)
        begin
            if (x < 0) x += w;
            if (x >= w) x -= w;
            if (y < 0) y += h;
            if (y >= h) y -= h;
        end
        if (x < 0 || y < 0 || x >= w || y >= h)
            return 0;
        return (cells[y * COLS + x] == ST_HEAD) ? 1 : 0;
    endfunction

    function automatic void advance_generation();
        int         w;
        int         h;
        int         n;
        logic [1:0] cur;
        logic [1:0] res;
        logic       any_live;
        w = active_cols();
        h = active_rows();
        any_live = 1'b0;
        for (int y = 0; y < h; y++)
        begin
            for (int x = 0; x < w; x++)
            begin
                cur = cells[y * COLS + x];
                case (cur)
                    ST_HEAD: res = ST_TAIL;
                    ST_TAIL: res = ST_COND;
                    ST_COND:
                    begin
                        n = 0;
                        // tiny wrapped grids may count the same cell several times
                        for (int dy = -1; dy <= 1; dy++)
                            for (int dx = -1; dx <= 1; dx++)
                                if (dx != 0 || dy != 0)
                                    n += head_at(x + dx, y + dy, w, h);
                        res = (n == 1 || n == 2) ? ST_HEAD : ST_COND;
                    end
                    default: res = ST_EMPTY;
                endcase
                if (res == ST_HEAD || res == ST_TAIL)
                    any_live = 1'b1;
                next_gen[y * COLS + x] = res;
            end
        end
        for (int y = 0; y < h; y++)
            for (int x = 0; x < w; x++)
                cells[y * COLS + x] = next_gen[y * COLS + x];
        live = any_live;
    endfunction

    function automatic rsp_t apply_request(req_t r);
        rsp_t o;
        logic hit;
        int   a;
        o = '0;
        hit = (int'(r.col) < active_cols()) && (int'(r.row) < active_rows());
        a = int'(r.row) * COLS + int'(r.col);
        case (r.op)
            OP_WRITE:
            begin
                if (hit)
                    cells[a] = r.new_state;
                o.in_range = hit;
            end
            OP_READ:
            begin
                if (hit)
                begin
                    o.cell_state = cells[a];
                    o.level = level_for(cells[a]);
                end
                o.in_range = hit;
            end
            OP_STEP: advance_generation();
            default: ;
        endcase
        o.live_electrons = live;
        return o;
    endfunction

    task automatic flag(string what, logic [15:0] got, logic [15:0] exp_val);
        fail_cnt++;
        if (fail_cnt <= 10)
            $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, what, exp_val, got);
    endtask

    task automatic check_reply(rsp_t got);
        if (pending_replies.size() == 0)
        begin
            fail_cnt++;
            if (fail_cnt <= 10)
                $display("%0t: rsp beat with nothing expected (state %0d level %0d)",
                         $realtime, got.cell_state, got.level);
        end
        else
        begin
            want = pending_replies.pop_front();
            if (got.cell_state !== want.cell_state)
                flag("cell_state", 16'(got.cell_state), 16'(want.cell_state));
            if (got.level !== want.level)
                flag("level", got.level, want.level);
            if (got.in_range !== want.in_range)
                flag("in_range", 16'(got.in_range), 16'(want.in_range));
            if (got.live_electrons !== want.live_electrons)
                flag("live_electrons", 16'(got.live_electrons), 16'(want.live_electrons));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CELLS; i++)
            begin
                cells[i] = ST_EMPTY;
                next_gen[i] = ST_EMPTY;
            end
            grid_w = DIM_RESET;
            grid_h = DIM_RESET;
            wrap_on = 1'b0;
            live = 1'b0;
            pending_replies.delete();
            fail_cnt = 0;
            replies_due <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_GRID_WIDTH:  grid_w = cfg_data;
                    REG_GRID_HEIGHT: grid_h = cfg_data;
                    REG_EDGE_WRAP:   wrap_on = cfg_data[0];
                    default: ;
                endcase
            end
            if (rsp_valid && !rsp_stall)
                check_reply(rsp);
            if (req_valid && !req_stall)
                pending_replies.push_back(apply_request(req));
            replies_due <= pending_replies.size();
        end
    end

endmodule

/* tb/wireworld_grid_engine_unit_test.sv */
// top of the wireworld grid engine testbench: clock, reset, req/cfg stimulus and rsp stalls
// depends on wwge_pkg, wireworld_grid_engine_unit and wireworld_grid_engine_checker

module wireworld_grid_engine_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import wwge_pkg::*;

    localparam logic [1:0] OP_NONE = 2'd3;
    localparam int IDLE_LIMIT = 100000;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  req_valid = 1'b0;
    logic                  req_stall;
    req_t                  req = '0;
    logic                  rsp_valid;
    logic                  rsp_stall = 1'b0;
    rsp_t                  rsp;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int unsigned fail_cnt;
    int unsigned replies_due;
    int          beats_left = 0;
    int          idle_cycles = 0;
    int          stall_mode = 0;
    int          stall_left = 0;

    wireworld_grid_engine_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    wireworld_grid_engine_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp         (rsp),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fail_cnt    (fail_cnt),
        .replies_due (replies_due)
    );

    always #5 clk = ~clk;

    // receiver stalls: each pattern holds for a random stretch
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(16, 200);
        end
        else
            stall_left <= stall_left - 1;
        case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= ~rsp_stall;
            default: rsp_stall <= ($urandom_range(0, 9) < 7);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)
                || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    task automatic send_op(logic [1:0] op, int c, int r, logic [1:0] ns);
        req_t item;
        int   gap;
        item.op = op;
        item.col = c[5:0];
        item.row = r[5:0];
        item.new_state = ns;
        if (beats_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            beats_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                      : $urandom_range(1, 8);
        end
        req <= item;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        beats_left--;
    endtask

    // stop sending and wait for every outstanding rsp beat
    task automatic drain();
        req_valid <= 1'b0;
        beats_left = 0;
        @(posedge clk);
        while (replies_due != 0)
            @(posedge clk);
    endtask

    task automatic put_reg(logic [CFG_IDX_W-1:0] idx, int d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d[CFG_DATA_W-1:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic program_grid(int w, int h, int wrap);
        drain();
        repeat (8) @(posedge clk);
        put_reg(REG_GRID_WIDTH, w);
        put_reg(REG_GRID_HEIGHT, h);
        put_reg(REG_EDGE_WRAP, wrap);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [1:0] pick_state();
        int p;
        p = $urandom_range(0, 19);
        if (p < 10) return ST_COND;
        if (p < 14) return ST_HEAD;
        if (p < 17) return ST_TAIL;
        return ST_EMPTY;
    endfunction

    // mostly small grids, now and then the largest, zero or oversize
    function automatic int pick_size();
        int p;
        p = $urandom_range(0, 9);
        if (p < 7) return $urandom_range(1, 8);
        if (p == 7) return $urandom_range(9, 64);
        if (p == 8) return ($urandom_range(0, 1) == 1) ? 0 : $urandom_range(65, 127);
        return 64;
    endfunction

    function automatic int pick_coord(int lim);
        if (lim == 0 || $urandom_range(0, 5) == 0)
            return $urandom_range(0, 63);
        return $urandom_range(0, lim - 1);
    endfunction

    task automatic random_phase();
        int w;
        int h;
        int we;
        int he;
        int n_steps;
        w = pick_size();
        h = pick_size();
        program_grid(w, h, $urandom_range(0, 1));
        we = (w > MAX_COLS_DEF) ? MAX_COLS_DEF : w;
        he = (h > MAX_ROWS_DEF) ? MAX_ROWS_DEF : h;
        // lay down a random pattern, then let it evolve and sample it
        repeat ($urandom_range(4, 10))
            send_op(OP_WRITE, pick_coord(we), pick_coord(he), pick_state());
        n_steps = (we * he > 256) ? 1 : $urandom_range(2, 4);
        repeat (n_steps)
        begin
            if ($urandom_range(0, 4) == 0)
                send_op(OP_NONE, $urandom_range(0, 63), $urandom_range(0, 63),
                        2'($urandom_range(0, 3)));
            send_op(OP_STEP, $urandom_range(0, 63), $urandom_range(0, 63),
                    2'($urandom_range(0, 3)));
            repeat ($urandom_range(1, 2))
                send_op(OP_READ, pick_coord(we), pick_coord(he), 2'($urandom_range(0, 3)));
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // full 64 x 64 grid with clipped edges, corners
        send_op(OP_WRITE, 0, 0, ST_HEAD);
        send_op(OP_WRITE, 63, 63, ST_COND);
        send_op(OP_WRITE, 63, 0, ST_TAIL);
        send_op(OP_WRITE, 0, 63, ST_EMPTY);
        send_op(OP_READ, 0, 0, ST_EMPTY);
        send_op(OP_READ, 63, 63, ST_EMPTY);
        send_op(OP_READ, 63, 0, ST_EMPTY);
        send_op(OP_NONE, 63, 63, ST_COND);
        send_op(OP_STEP, 0, 0, ST_EMPTY);
        send_op(OP_READ, 63, 0, ST_EMPTY);

        // zero width: everything out of range, step clears the live flag
        program_grid(0, 5, 0);
        send_op(OP_WRITE, 0, 0, ST_COND);
        send_op(OP_READ, 0, 0, ST_EMPTY);
        send_op(OP_STEP, 0, 0, ST_EMPTY);

        // oversize width saturates; two rows wrapped
        program_grid(127, 2, 1);
        send_op(OP_READ, 63, 0, ST_EMPTY);
        send_op(OP_READ, 0, 2, ST_EMPTY);
        send_op(OP_STEP, 0, 0, ST_EMPTY);

        // two-cell wrapped ring: the same neighbour is counted several times
        program_grid(2, 1, 1);
        send_op(OP_WRITE, 0, 0, ST_HEAD);
        send_op(OP_WRITE, 1, 0, ST_COND);
        send_op(OP_STEP, 0, 0, ST_EMPTY);
        send_op(OP_READ, 1, 0, ST_EMPTY);
        send_op(OP_STEP, 0, 0, ST_EMPTY);
        send_op(OP_READ, 0, 0, ST_EMPTY);

        repeat (9)
            random_phase();

        drain();
        repeat (20) @(posedge clk);
        if (fail_cnt == 0 && replies_due == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
